[hdl/pcsd_pkg.sv]
// pcsd_pkg: shared types and constants of the prefix code stream decoder
// holds the stream phase and sequencer enums and the result status codes
// no dependencies
package pcsd_pkg;

	localparam int SYM_W       = 8;
	localparam int NUM_SYMBOLS = 256;
	localparam int COUNT_W     = 32;

	typedef enum logic [2:0] {
		PH_COUNT,
		PH_WIDTH,
		PH_TABLE,
		PH_DATA,
		PH_IDLE
	} phase_t;

	typedef enum logic [3:0] {
		SQ_IDLE,
		SQ_BYTE,
		SQ_ROOT,
		SQ_TBIT,
		SQ_INS_RD,
		SQ_INS_CHK,
		SQ_INS_NEW,
		SQ_DBIT,
		SQ_DUSE,
		SQ_FIN
	} seq_t;

	typedef enum logic [1:0] {
		ST_SYMBOL   = 2'd0,
		ST_BAD_CODE = 2'd1,
		ST_WIDTH    = 2'd2,
		ST_EARLY    = 2'd3
	} status_t;

endpackage

[hdl/prefix_code_stream_decoder_unit.sv]
// prefix_code_stream_decoder_unit: decodes a packed prefix-code stream into byte symbols
// depends on pcsd_pkg
// input: one stream byte per transaction on s_axis, tlast marks the final byte of a stream;
// a stream is a 4-byte big-endian symbol count, a code width byte, a 256-entry code table,
// then coded data bits taken msb first
// output: one result per transaction on m_axis, tdata the symbol, tuser the status
// (symbol, bad code, width too large, stream ended early), tlast on the final symbol and on
// every error result
// table entries are inserted into a binary code tree held in an on-chip node memory;
// data bits walk that tree one bit at a time
// per byte: a count byte is shifted into the symbol count; the width byte is checked and, when
// in range, the tree root is cleared; a table byte is taken bit by bit, and each completed entry
// walks the tree level by level, adding new nodes where a path is missing, then marks its leaf;
// a data byte walks the tree bit by bit, each tree step paced by the registered read of the node
// memory; a new stream byte is accepted only once the current byte is finished
// a result waits in the output register while m_axis_tready is low; the bit walk goes on
// and halts only at the next result, which waits until the output register is free
// reset clears the sequencer and the output valid flag; the code table is rebuilt per stream
module prefix_code_stream_decoder_unit #(
	parameter int MAX_CODE_LEN = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // [7:0] data_byte
	input  logic       s_axis_tlast,
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,  // [7:0] symbol
	output logic [1:0] m_axis_tuser,  // [1:0] status
	output logic       m_axis_tlast
);

	localparam int CW    = $clog2(MAX_CODE_LEN + 1);
	localparam int NODES = pcsd_pkg::NUM_SYMBOLS * MAX_CODE_LEN + 1;
	localparam int PW    = $clog2(NODES);
	localparam int SW    = pcsd_pkg::SYM_W;

	typedef struct packed {
		logic [PW-1:0] c0;
		logic [PW-1:0] c1;
		logic          leaf;
		logic [SW-1:0] sym;
	} node_t;

	// sequencer and stream control
	pcsd_pkg::seq_t   state_q, state_d;
	pcsd_pkg::phase_t phase_q, phase_d;
	logic [1:0]       hdr_idx_q, hdr_idx_d;
	logic [2:0]       bit_idx_q, bit_idx_d;
	logic [2:0]       n_emit_q, n_emit_d;
	logic [CW-1:0]    plen_q, plen_d;
	logic             dead_q, dead_d;
	logic             marker_q, marker_d;
	logic             out_valid_q, out_valid_d;

	// payload
	logic [SW-1:0]           sh_q, sh_d;
	logic                    eos_q, eos_d;
	logic [pcsd_pkg::COUNT_W-1:0] symbols_left_q, symbols_left_d;
	logic [CW-1:0]           code_width_q, code_width_d;
	logic [CW-1:0]           pos_q, pos_d;
	logic [CW-1:0]           len_q, len_d;
	logic [MAX_CODE_LEN-1:0] code_q, code_d;
	logic [SW-1:0]           entry_idx_q, entry_idx_d;
	logic [MAX_CODE_LEN-1:0] ins_sh_q, ins_sh_d;
	logic [CW-1:0]           ins_len_q, ins_len_d;
	logic [SW-1:0]           ins_sym_q, ins_sym_d;
	logic [CW-1:0]           depth_q, depth_d;
	logic [PW-1:0]           cur_q, cur_d;
	logic                    ret_fin_q, ret_fin_d;
	logic [PW-1:0]           alloc_q, alloc_d;
	node_t                   root_q, root_d;
	node_t                   node_q, node_d;
	logic [SW-1:0]           out_sym_q, out_sym_d;
	logic [1:0]              out_status_q, out_status_d;
	logic                    out_last_q, out_last_d;

	// node memory
	node_t         mem [0:NODES-1];
	node_t         rd_q;
	logic [PW-1:0] rd_addr;
	logic          mem_we;
	logic [PW-1:0] mem_wa;
	node_t         mem_wd;

	// combinational helpers
	logic                  can_emit;
	logic                  last_bit;
	logic                  tb;
	node_t                 cur_node;
	logic [PW-1:0]         dchild;
	logic [CW-1:0]         plen_n;
	logic [MAX_CODE_LEN:0] code_ext;
	logic [MAX_CODE_LEN-1:0] code_next;
	logic                  entry_done;
	logic                  table_end;
	logic                  ib;
	logic [PW-1:0]         ichild;
	logic                  final_sym;
	logic                  replace;
	node_t                 link;

	assign s_axis_tready = (state_q == pcsd_pkg::SQ_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_sym_q;
	assign m_axis_tuser  = out_status_q;
	assign m_axis_tlast  = out_last_q;

	always_comb begin
		can_emit   = !out_valid_q || m_axis_tready;
		last_bit   = (bit_idx_q == 3'd7);
		tb         = sh_q[SW-1];
		cur_node   = (plen_q == '0) ? root_q : node_q;
		dchild     = tb ? cur_node.c1 : cur_node.c0;
		plen_n     = plen_q + CW'(1);
		code_ext   = {code_q, tb};
		code_next  = code_ext[MAX_CODE_LEN-1:0];
		entry_done = (pos_q == code_width_q);
		table_end  = entry_done && (entry_idx_q == SW'(pcsd_pkg::NUM_SYMBOLS - 1));
		ib         = ins_sh_q[MAX_CODE_LEN-1];
		ichild     = ib ? rd_q.c1 : rd_q.c0;
		final_sym  = (symbols_left_q == pcsd_pkg::COUNT_W'(1));
		replace    = eos_q && last_bit && (n_emit_q == 3'd7) && !final_sym;
		link       = rd_q;
		if (ib) begin
			link.c1 = alloc_q;
		end else begin
			link.c0 = alloc_q;
		end

		state_d        = state_q;
		phase_d        = phase_q;
		hdr_idx_d      = hdr_idx_q;
		bit_idx_d      = bit_idx_q;
		n_emit_d       = n_emit_q;
		plen_d         = plen_q;
		dead_d         = dead_q;
		marker_d       = marker_q;
		sh_d           = sh_q;
		eos_d          = eos_q;
		symbols_left_d = symbols_left_q;
		code_width_d   = code_width_q;
		pos_d          = pos_q;
		len_d          = len_q;
		code_d         = code_q;
		entry_idx_d    = entry_idx_q;
		ins_sh_d       = ins_sh_q;
		ins_len_d      = ins_len_q;
		ins_sym_d      = ins_sym_q;
		depth_d        = depth_q;
		cur_d          = cur_q;
		ret_fin_d      = ret_fin_q;
		alloc_d        = alloc_q;
		node_d         = node_q;
		rd_addr        = cur_q;
		mem_we         = 1'b0;
		mem_wa         = cur_q;
		mem_wd         = '0;
		out_valid_d    = out_valid_q && !m_axis_tready;
		out_sym_d      = out_sym_q;
		out_status_d   = out_status_q;
		out_last_d     = out_last_q;

		case (state_q)
			pcsd_pkg::SQ_IDLE: begin
				if (s_axis_tvalid) begin
					sh_d      = s_axis_tdata;
					eos_d     = s_axis_tlast;
					bit_idx_d = 3'd0;
					n_emit_d  = 3'd0;
					state_d   = pcsd_pkg::SQ_BYTE;
				end
			end
			pcsd_pkg::SQ_BYTE: begin
				case (phase_q)
					pcsd_pkg::PH_COUNT: begin
						symbols_left_d = {symbols_left_q[pcsd_pkg::COUNT_W-SW-1:0], sh_q};
						hdr_idx_d      = hdr_idx_q + 2'd1;
						if (hdr_idx_q == 2'd3) begin
							phase_d = pcsd_pkg::PH_WIDTH;
						end
						state_d = pcsd_pkg::SQ_FIN;
					end
					pcsd_pkg::PH_WIDTH: begin
						if (sh_q > SW'(MAX_CODE_LEN)) begin
							if (can_emit) begin
								out_valid_d  = 1'b1;
								out_sym_d    = '0;
								out_status_d = pcsd_pkg::ST_WIDTH;
								out_last_d   = 1'b1;
								phase_d      = pcsd_pkg::PH_IDLE;
								state_d      = pcsd_pkg::SQ_FIN;
							end
						end else begin
							code_width_d = sh_q[CW-1:0];
							pos_d        = '0;
							marker_d     = 1'b0;
							entry_idx_d  = '0;
							phase_d      = pcsd_pkg::PH_TABLE;
							state_d      = pcsd_pkg::SQ_ROOT;
						end
					end
					pcsd_pkg::PH_TABLE: state_d = pcsd_pkg::SQ_TBIT;
					pcsd_pkg::PH_DATA:  state_d = pcsd_pkg::SQ_DBIT;
					default:            state_d = pcsd_pkg::SQ_FIN;
				endcase
			end
			pcsd_pkg::SQ_ROOT: begin
				mem_we  = 1'b1;
				mem_wa  = '0;
				mem_wd  = '0;
				alloc_d = PW'(1);
				state_d = pcsd_pkg::SQ_FIN;
			end
			pcsd_pkg::SQ_TBIT: begin
				sh_d      = {sh_q[SW-2:0], 1'b0};
				bit_idx_d = bit_idx_q + 3'd1;
				state_d   = (last_bit || table_end) ? pcsd_pkg::SQ_FIN : pcsd_pkg::SQ_TBIT;
				if (entry_done) begin
					pos_d       = '0;
					marker_d    = 1'b0;
					entry_idx_d = entry_idx_q + SW'(1);
					if (marker_q) begin
						ins_sh_d  = code_next << (CW'(MAX_CODE_LEN) - len_q);
						ins_len_d = len_q;
						ins_sym_d = entry_idx_q;
						depth_d   = '0;
						cur_d     = '0;
						ret_fin_d = last_bit || table_end;
						state_d   = pcsd_pkg::SQ_INS_RD;
					end
				end else begin
					pos_d = pos_q + CW'(1);
					if (marker_q) begin
						code_d = code_next;
					end else if (tb) begin
						marker_d = 1'b1;
						len_d    = code_width_q - pos_q;
						code_d   = '0;
					end
				end
				if (table_end) begin
					phase_d = (symbols_left_q == '0) ? pcsd_pkg::PH_IDLE : pcsd_pkg::PH_DATA;
					plen_d  = '0;
					dead_d  = 1'b0;
				end
			end
			pcsd_pkg::SQ_INS_RD: begin
				rd_addr = cur_q;
				state_d = pcsd_pkg::SQ_INS_CHK;
			end
			pcsd_pkg::SQ_INS_CHK: begin
				if (depth_q == ins_len_q) begin
					mem_we      = 1'b1;
					mem_wa      = cur_q;
					mem_wd      = rd_q;
					mem_wd.leaf = 1'b1;
					mem_wd.sym  = ins_sym_q;
					state_d     = ret_fin_q ? pcsd_pkg::SQ_FIN : pcsd_pkg::SQ_TBIT;
				end else if (ichild != '0) begin
					cur_d    = ichild;
					depth_d  = depth_q + CW'(1);
					ins_sh_d = ins_sh_q << 1;
					state_d  = pcsd_pkg::SQ_INS_RD;
				end else begin
					mem_we  = 1'b1;
					mem_wa  = cur_q;
					mem_wd  = link;
					cur_d   = alloc_q;
					state_d = pcsd_pkg::SQ_INS_NEW;
				end
			end
			pcsd_pkg::SQ_INS_NEW: begin
				mem_we   = 1'b1;
				mem_wa   = cur_q;
				mem_wd   = '0;
				alloc_d  = alloc_q + PW'(1);
				depth_d  = depth_q + CW'(1);
				ins_sh_d = ins_sh_q << 1;
				state_d  = pcsd_pkg::SQ_INS_RD;
			end
			pcsd_pkg::SQ_DBIT: begin
				if (dead_q || dchild == '0) begin
					if (plen_n >= code_width_q) begin
						if (can_emit) begin
							out_valid_d  = 1'b1;
							out_sym_d    = '0;
							out_status_d = pcsd_pkg::ST_BAD_CODE;
							out_last_d   = 1'b1;
							phase_d      = pcsd_pkg::PH_IDLE;
							plen_d       = plen_n;
							dead_d       = 1'b1;
							state_d      = pcsd_pkg::SQ_FIN;
						end
					end else begin
						plen_d    = plen_n;
						dead_d    = 1'b1;
						sh_d      = {sh_q[SW-2:0], 1'b0};
						bit_idx_d = bit_idx_q + 3'd1;
						state_d   = last_bit ? pcsd_pkg::SQ_FIN : pcsd_pkg::SQ_DBIT;
					end
				end else begin
					// keep the child address so the read holds while a result waits
					rd_addr = dchild;
					cur_d   = dchild;
					plen_d  = plen_n;
					sh_d    = {sh_q[SW-2:0], 1'b0};
					state_d = pcsd_pkg::SQ_DUSE;
				end
			end
			pcsd_pkg::SQ_DUSE: begin
				if (rd_q.leaf) begin
					if (can_emit) begin
						out_valid_d    = 1'b1;
						out_sym_d      = replace ? '0 : rd_q.sym;
						out_status_d   = replace ? pcsd_pkg::ST_EARLY : pcsd_pkg::ST_SYMBOL;
						out_last_d     = final_sym || replace;
						symbols_left_d = symbols_left_q - pcsd_pkg::COUNT_W'(1);
						plen_d         = '0;
						dead_d         = 1'b0;
						n_emit_d       = n_emit_q + 3'd1;
						bit_idx_d      = bit_idx_q + 3'd1;
						if (final_sym || replace) begin
							phase_d = pcsd_pkg::PH_IDLE;
							state_d = pcsd_pkg::SQ_FIN;
						end else begin
							state_d = last_bit ? pcsd_pkg::SQ_FIN : pcsd_pkg::SQ_DBIT;
						end
					end
				end else if (plen_q >= code_width_q) begin
					if (can_emit) begin
						out_valid_d  = 1'b1;
						out_sym_d    = '0;
						out_status_d = pcsd_pkg::ST_BAD_CODE;
						out_last_d   = 1'b1;
						phase_d      = pcsd_pkg::PH_IDLE;
						state_d      = pcsd_pkg::SQ_FIN;
					end
				end else begin
					node_d    = rd_q;
					bit_idx_d = bit_idx_q + 3'd1;
					state_d   = last_bit ? pcsd_pkg::SQ_FIN : pcsd_pkg::SQ_DBIT;
				end
			end
			pcsd_pkg::SQ_FIN: begin
				if (eos_q) begin
					if (phase_q != pcsd_pkg::PH_IDLE) begin
						if (can_emit) begin
							out_valid_d  = 1'b1;
							out_sym_d    = '0;
							out_status_d = pcsd_pkg::ST_EARLY;
							out_last_d   = 1'b1;
							phase_d      = pcsd_pkg::PH_COUNT;
							hdr_idx_d    = 2'd0;
							plen_d       = '0;
							dead_d       = 1'b0;
							state_d      = pcsd_pkg::SQ_IDLE;
						end
					end else begin
						phase_d   = pcsd_pkg::PH_COUNT;
						hdr_idx_d = 2'd0;
						plen_d    = '0;
						dead_d    = 1'b0;
						state_d   = pcsd_pkg::SQ_IDLE;
					end
				end else begin
					state_d = pcsd_pkg::SQ_IDLE;
				end
			end
			default: state_d = pcsd_pkg::SQ_IDLE;
		endcase

		root_d = root_q;
		if (mem_we && mem_wa == '0) begin
			root_d = mem_wd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pcsd_pkg::SQ_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= pcsd_pkg::PH_COUNT;
			hdr_idx_q   <= 2'd0;
			bit_idx_q   <= 3'd0;
			n_emit_q    <= 3'd0;
			plen_q      <= '0;
			dead_q      <= 1'b0;
			marker_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			phase_q     <= phase_d;
			hdr_idx_q   <= hdr_idx_d;
			bit_idx_q   <= bit_idx_d;
			n_emit_q    <= n_emit_d;
			plen_q      <= plen_d;
			dead_q      <= dead_d;
			marker_q    <= marker_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		sh_q           <= sh_d;
		eos_q          <= eos_d;
		symbols_left_q <= symbols_left_d;
		code_width_q   <= code_width_d;
		pos_q          <= pos_d;
		len_q          <= len_d;
		code_q         <= code_d;
		entry_idx_q    <= entry_idx_d;
		ins_sh_q       <= ins_sh_d;
		ins_len_q      <= ins_len_d;
		ins_sym_q      <= ins_sym_d;
		depth_q        <= depth_d;
		cur_q          <= cur_d;
		ret_fin_q      <= ret_fin_d;
		alloc_q        <= alloc_d;
		root_q         <= root_d;
		node_q         <= node_d;
		out_sym_q      <= out_sym_d;
		out_status_q   <= out_status_d;
		out_last_q     <= out_last_d;
	end

	// code tree node memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_q <= mem[rd_addr];
	end

endmodule

[tb/prefix_code_stream_decoder_unit_test.sv]
`timescale 1ns / 100ps
// prefix_code_stream_decoder_unit_test: self-checking bench for the prefix code stream decoder
// builds packed streams (count, width, code table, coded data) and decodes each accepted byte
// in a local model to check every m_axis transaction in order; depends on pcsd_pkg and the unit
module prefix_code_stream_decoder_unit_test;

	localparam int CODE_LEN_MAX = 16;
	localparam int QUIET_LIMIT  = 20000;
	localparam int TAIL_CYCLES  = 100;

	typedef enum int {
		SK_FULL,
		SK_SHORT_COUNT,
		SK_LONG_COUNT,
		SK_GARBAGE,
		SK_ZERO_COUNT,
		SK_CUT_TABLE
	} stream_kind_t;

	typedef struct {
		bit [7:0] data;
		bit       eos;
		int       gap;
		bit       drain;
		bit       calm;
	} stream_byte_t;

	typedef struct {
		bit [7:0]          symbol;
		pcsd_pkg::status_t status;
		bit                is_last;
	} decode_result_t;

	logic       clk;
	logic       arst_n        = 1'b0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata  = 8'd0;  // [7:0] data_byte
	logic       s_axis_tlast  = 1'b0;
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;          // [7:0] symbol
	logic [1:0] m_axis_tuser;          // [1:0] status
	logic       m_axis_tlast;

	stream_byte_t   stim_q[$];
	decode_result_t decoded_q[$];
	bit             stream_bits[$];
	stream_byte_t   next_item;
	int             errors_seen   = 0;
	int             streams_built = 0;
	bit             gen_gappy     = 1'b1;
	bit             gen_calm      = 1'b0;
	bit             in_fire       = 1'b0;
	int             in_gap        = 0;
	bit             tail_calm     = 1'b0;
	int             stall_left    = 0;
	bit             stall_mode    = 1'b1;
	int             quiet_cycles  = 0;

	// decoder state mirror
	pcsd_pkg::phase_t dec_phase = pcsd_pkg::PH_COUNT;
	int unsigned hdr_idx   = 0;
	bit [31:0]   sym_left  = 0;
	bit [4:0]    cw        = 0;
	int unsigned tbit      = 0;
	bit [16:0]   entry     = 0;
	bit [4:0]    code_len_tbl  [pcsd_pkg::NUM_SYMBOLS];
	bit [15:0]   code_bits_tbl [pcsd_pkg::NUM_SYMBOLS];
	bit [23:0]   pcode     = 0;
	int unsigned plen      = 0;

	prefix_code_stream_decoder_unit #(
		.MAX_CODE_LEN(CODE_LEN_MAX)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void decode_stream_byte(input bit [7:0] b, input bit eos);
		int unsigned ew;
		int          j, p, s, found, n;
		n = 0;
		case (dec_phase)
			pcsd_pkg::PH_COUNT: begin
				sym_left = (hdr_idx == 0) ? {24'd0, b} : {sym_left[23:0], b};
				hdr_idx++;
				if (hdr_idx >= 4) begin
					hdr_idx = 0;
					dec_phase = pcsd_pkg::PH_WIDTH;
				end
			end
			pcsd_pkg::PH_WIDTH: begin
				if (b > CODE_LEN_MAX) begin
					decoded_q.push_back('{8'd0, pcsd_pkg::ST_WIDTH, 1'b1});
					n++;
					dec_phase = pcsd_pkg::PH_IDLE;
				end else begin
					cw = b[4:0];
					tbit = 0;
					entry = 0;
					dec_phase = pcsd_pkg::PH_TABLE;
				end
			end
			pcsd_pkg::PH_TABLE: begin
				ew = cw + 1;
				for (j = 0; j < 8; j++) begin
					entry = 17'(((32'(entry) << 1) | b[7 - j]) & ((32'd1 << ew) - 1));
					if (tbit % ew == cw) begin
						s = tbit / ew;
						code_len_tbl[s] = 0;
						code_bits_tbl[s] = 0;
						for (p = 0; p < cw; p++) begin
							if (entry[cw - p]) begin
								code_len_tbl[s] = 5'(cw - p);
								code_bits_tbl[s] = 16'(entry & ((32'd1 << (cw - p)) - 1));
								break;
							end
						end
						entry = 0;
					end
					tbit++;
					if (tbit >= pcsd_pkg::NUM_SYMBOLS * ew) begin
						pcode = 0;
						plen = 0;
						dec_phase = (sym_left == 0) ? pcsd_pkg::PH_IDLE : pcsd_pkg::PH_DATA;
						break;
					end
				end
			end
			pcsd_pkg::PH_DATA: begin
				for (j = 0; j < 8 && dec_phase == pcsd_pkg::PH_DATA; j++) begin
					pcode = {pcode[22:0], b[7 - j]};
					plen++;
					found = -1;
					for (s = 0; s < pcsd_pkg::NUM_SYMBOLS; s++) begin
						if (code_len_tbl[s] != 0 && code_len_tbl[s] == plen &&
								code_bits_tbl[s] == pcode)
							found = s;
					end
					if (found >= 0) begin
						sym_left--;
						pcode = 0;
						plen = 0;
						decoded_q.push_back('{8'(found), pcsd_pkg::ST_SYMBOL, sym_left == 0});
						n++;
						if (sym_left == 0)
							dec_phase = pcsd_pkg::PH_IDLE;
					end else if (plen >= cw) begin
						decoded_q.push_back('{8'd0, pcsd_pkg::ST_BAD_CODE, 1'b1});
						n++;
						dec_phase = pcsd_pkg::PH_IDLE;
					end
				end
			end
			default: ;
		endcase
		if (eos) begin
			if (dec_phase != pcsd_pkg::PH_IDLE) begin
				// an early end takes the place of an eighth symbol
				if (n >= 8)
					void'(decoded_q.pop_back());
				decoded_q.push_back('{8'd0, pcsd_pkg::ST_EARLY, 1'b1});
			end
			dec_phase = pcsd_pkg::PH_COUNT;
			hdr_idx = 0;
			pcode = 0;
			plen = 0;
		end
	endfunction

	function automatic void put_byte(input bit [7:0] d, input bit eos);
		stream_byte_t it;
		it.data = d;
		it.eos = eos;
		it.gap = (gen_gappy && $urandom_range(0, 4) == 0) ? $urandom_range(1, 6) : 0;
		it.drain = 1'b0;
		it.calm = gen_calm;
		stim_q.push_back(it);
	endfunction

	function automatic void add_bits(input bit [31:0] v, input int n);
		int i;
		for (i = n - 1; i >= 0; i--)
			stream_bits.push_back(v[i]);
	endfunction

	function automatic void build_stream(input int w, input stream_kind_t kind);
		bit [4:0]  leaf_len  [pcsd_pkg::NUM_SYMBOLS];
		bit [15:0] leaf_bits [pcsd_pkg::NUM_SYMBOLS];
		bit [4:0]  code_len  [pcsd_pkg::NUM_SYMBOLS];
		bit [15:0] code_bits [pcsd_pkg::NUM_SYMBOLS];
		int        coded_leaves[$];
		bit [7:0]  packed_bytes[$];
		bit [7:0]  b;
		bit [31:0] count;
		int        n_leaf, n_sym, cap, i, k, s, t, keep, first;
		code_len = '{default: 0};
		code_bits = '{default: 0};
		leaf_len[0] = 0;
		leaf_bits[0] = 0;
		n_leaf = 1;
		if (w > 0) begin
			// grow a prefix code tree by splitting leaves, often the newest one
			cap = (w < 6) ? (1 << w) - 1 : 60;
			t = (w == CODE_LEN_MAX) ? 60 : $urandom_range(1, cap);
			for (i = 0; i < t; i++) begin
				k = ($urandom_range(0, 1) != 0) ? n_leaf - 1 : $urandom_range(0, n_leaf - 1);
				if (leaf_len[k] < w) begin
					leaf_len[n_leaf] = leaf_len[k] + 5'd1;
					leaf_bits[n_leaf] = {leaf_bits[k][14:0], 1'b1};
					leaf_len[k] = leaf_len[k] + 5'd1;
					leaf_bits[k] = {leaf_bits[k][14:0], 1'b0};
					n_leaf++;
				end
			end
			for (k = 0; k < n_leaf; k++) begin
				if (w == 1 || $urandom_range(0, 9) != 0) begin
					do s = $urandom_range(0, pcsd_pkg::NUM_SYMBOLS - 1); while (code_len[s] != 0);
					code_len[s] = leaf_len[k];
					code_bits[s] = leaf_bits[k];
					coded_leaves.push_back(k);
				end
			end
			// duplicate code or shorter prefix on a spare symbol
			if (coded_leaves.size() != 0 && $urandom_range(0, 2) == 0) begin
				k = coded_leaves[$urandom_range(0, coded_leaves.size() - 1)];
				do s = $urandom_range(0, pcsd_pkg::NUM_SYMBOLS - 1); while (code_len[s] != 0);
				code_len[s] = leaf_len[k];
				code_bits[s] = leaf_bits[k];
				if (leaf_len[k] > 1 && $urandom_range(0, 1) != 0) begin
					code_len[s] = leaf_len[k] - 5'd1;
					code_bits[s] = leaf_bits[k] >> 1;
				end
			end
		end
		n_sym = $urandom_range(2, (w == CODE_LEN_MAX) ? 12 : 20);
		case (kind)
			SK_FULL:        count = n_sym;
			SK_SHORT_COUNT: count = $urandom_range(1, n_sym - 1);
			SK_LONG_COUNT: begin
				case ($urandom_range(0, 3))
					0:       count = '1;
					1:       count = $urandom;
					default: count = n_sym + $urandom_range(1, 3);
				endcase
			end
			SK_ZERO_COUNT:  count = 0;
			default:        count = $urandom_range(1, 40);
		endcase
		add_bits(count, 32);
		add_bits(w, 8);
		for (s = 0; s < pcsd_pkg::NUM_SYMBOLS; s++) begin
			if (code_len[s] != 0) begin
				add_bits(0, w - int'(code_len[s]));
				add_bits(1, 1);
				add_bits(32'(code_bits[s]), int'(code_len[s]));
			end else begin
				add_bits(0, w);
				add_bits($urandom_range(0, 1), 1);
			end
		end
		if (kind == SK_GARBAGE || coded_leaves.size() == 0) begin
			repeat ($urandom_range(1, 4))
				add_bits($urandom_range(0, 255), 8);
		end else begin
			repeat (n_sym) begin
				k = coded_leaves[$urandom_range(0, coded_leaves.size() - 1)];
				add_bits(32'(leaf_bits[k]), int'(leaf_len[k]));
			end
		end
		while (stream_bits.size() != 0) begin
			for (i = 0; i < 8; i++) begin
				if (stream_bits.size() != 0)
					b = {b[6:0], stream_bits.pop_front()};
				else
					b = {b[6:0], 1'($urandom_range(0, 1))};
			end
			packed_bytes.push_back(b);
		end
		if (kind == SK_CUT_TABLE) begin
			keep = 5 + $urandom_range(0, 32 * (w + 1) - 1);
		end else begin
			repeat ($urandom_range(0, 2))
				packed_bytes.push_back(8'($urandom_range(0, 255)));
			keep = packed_bytes.size();
		end
		first = stim_q.size();
		for (i = 0; i < keep; i++)
			put_byte(packed_bytes[i], i == keep - 1);
		stim_q[first].drain = (streams_built % 4 == 1);
		streams_built++;
	endfunction

	initial begin
		// early end inside the count header
		put_byte(8'h00, 1'b0);
		put_byte(8'h00, 1'b1);
		// width one above the limit, closing byte ignored
		put_byte(8'h00, 1'b0);
		put_byte(8'h00, 1'b0);
		put_byte(8'h00, 1'b0);
		put_byte(8'h05, 1'b0);
		put_byte(8'(CODE_LEN_MAX + 1), 1'b0);
		put_byte(8'hFF, 1'b1);
		// all-ones count and width, end flag on the width byte
		repeat (4)
			put_byte(8'hFF, 1'b0);
		put_byte(8'hFF, 1'b1);
		// widest legal width, stream cut right after it
		put_byte(8'h00, 1'b0);
		put_byte(8'h00, 1'b0);
		put_byte(8'h00, 1'b0);
		put_byte(8'h01, 1'b0);
		put_byte(8'(CODE_LEN_MAX), 1'b1);
		// zero width, stream cut right after it
		put_byte(8'h80, 1'b0);
		put_byte(8'h00, 1'b0);
		put_byte(8'h00, 1'b0);
		put_byte(8'h00, 1'b0);
		put_byte(8'h00, 1'b1);
		build_stream(0, SK_ZERO_COUNT);
		build_stream(0, SK_GARBAGE);
		build_stream(2, SK_FULL);
		gen_gappy = 1'b0;
		gen_calm = 1'b1;
		build_stream(1, SK_LONG_COUNT);

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		while (stim_q.size() != 0 || s_axis_tvalid)
			@(negedge clk);
		while (decoded_q.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
		if (errors_seen == 0 && decoded_q.size() == 0)
			$display("PASS prefix_code_stream_decoder_unit");
		else
			$display("FAIL prefix_code_stream_decoder_unit");
		$finish;
	end

	// byte sender
	always @(negedge clk) begin
		if (arst_n && (in_fire || !s_axis_tvalid)) begin
			if (in_gap != 0) begin
				in_gap--;
				s_axis_tvalid <= 1'b0;
			end else if (stim_q.size() == 0) begin
				s_axis_tvalid <= 1'b0;
			end else if (stim_q[0].gap != 0) begin
				in_gap = stim_q[0].gap - 1;
				stim_q[0].gap = 0;
				s_axis_tvalid <= 1'b0;
			end else if (stim_q[0].drain && decoded_q.size() != 0) begin
				s_axis_tvalid <= 1'b0;
			end else begin
				next_item = stim_q.pop_front();
				tail_calm = next_item.calm;
				s_axis_tdata <= next_item.data;
				s_axis_tlast <= next_item.eos;
				s_axis_tvalid <= 1'b1;
			end
		end
	end

	// result receiver
	always @(negedge clk) begin
		if (stall_left != 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else if (!tail_calm && stall_mode && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(0, 5);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
		if ($urandom_range(0, 149) == 0)
			stall_mode = !stall_mode;
	end

	always @(posedge clk) begin
		decode_result_t want;
		in_fire = arst_n && s_axis_tvalid && s_axis_tready;
		if (in_fire)
			decode_stream_byte(s_axis_tdata, s_axis_tlast);
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (decoded_q.size() == 0) begin
				$error("unexpected transaction: symbol %0d status %0d last %0b",
					m_axis_tdata, m_axis_tuser, m_axis_tlast);
				errors_seen++;
			end else begin
				want = decoded_q.pop_front();
				if (m_axis_tdata !== want.symbol) begin
					$error("symbol: expected %0d, got %0d", want.symbol, m_axis_tdata);
					errors_seen++;
				end
				if (m_axis_tuser !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, m_axis_tuser);
					errors_seen++;
				end
				if (m_axis_tlast !== want.is_last) begin
					$error("last: expected %0b, got %0b", want.is_last, m_axis_tlast);
					errors_seen++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$error("no transaction for %0d cycles", quiet_cycles);
			$display("FAIL prefix_code_stream_decoder_unit");
			$finish;
		end
	end

endmodule
